>>> src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int TREE_LEVELS = 5;
  localparam int SIZE_BITS   = 16;
  localparam int NODE_BITS   = TREE_LEVELS;
  localparam int NODE_COUNT  = 1 << TREE_LEVELS;
  localparam int LVL_BITS    = 3;
  localparam logic [SIZE_BITS-1:0] TOTAL_RESET = SIZE_BITS'(1024);
  localparam int NODE_W      = 2 + SIZE_BITS;

  typedef enum logic [1:0] {
    ST_FREE    = 2'd0,
    ST_DIVIDED = 2'd1,
    ST_ALLOC   = 2'd2
  } node_st_t;

  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_EXCEEDS   = 3'd1,
    RES_NO_FREE   = 3'd2,
    RES_NOT_FOUND = 3'd3,
    RES_ZERO      = 3'd4
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_LEVEL, S_SCAN, S_ANC, S_MARK, S_FSCAN, S_MERGE, S_DONE
  } fsm_t;

  // Datapath commands
  typedef struct packed {
    logic clear_init;
    logic clear_step;
    logic load;        // latch item, start level search
    logic level_step;
    logic scan_init;   // start alloc scan at level
    logic scan_rd;     // candidate is free: start ancestor walk at its parent
    logic anc_step;    // step ancestor walk
    logic scan_next;
    logic take;        // allocate candidate, start marking
    logic mark_step;
    logic fscan_init;
    logic fscan_next;
    logic free_take;
    logic merge_step;
    logic set_res;
    res_t res;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic zero_req;
    logic is_free;
    logic exceeds;
    logic level_done;
    logic rd_valid;    // read data from last access is ready
    logic cand_free;
    logic anc_done;
    logic anc_ok;
    logic scan_last;
    logic mark_done;
    logic fmatch;
    logic fscan_last;
    logic merge_done;
  } sts_t;

endpackage

>>> src/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> src/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Node store, address and size registers, result registers.
// ----------------------------------------------------------------------------
module bba_datapath
  import bba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 cfg_wr_en,
  input  logic [SIZE_BITS-1:0] cfg_wr_data,
  input  logic                 in_kind,
  input  logic [SIZE_BITS-1:0] in_request_size,
  output logic [2:0]           res_status,
  output logic [NODE_BITS-1:0] res_node,
  output logic [LVL_BITS-1:0]  res_level
);

  logic [SIZE_BITS-1:0] total_r;
  logic [LVL_BITS-1:0]  deep_r;
  logic [SIZE_BITS-1:0] req_r;
  logic [SIZE_BITS-1:0] sz_r;
  logic [LVL_BITS-1:0]  lvl_r;
  logic [NODE_BITS-1:0] cand_r;   // candidate / found node
  logic [NODE_BITS-1:0] ptr_r;    // walk pointer
  logic [NODE_BITS:0]   fend_r;   // free scan limit
  logic                 rdq_r;    // address of a new read is on the port
  logic                 rdv_r;
  logic [2:0]           st_r;
  logic [NODE_BITS-1:0] nd_r;
  logic [LVL_BITS-1:0]  lv_r;

  logic                 we;
  logic [NODE_BITS-1:0] addr;
  logic [NODE_W-1:0]    wdata, rdata;
  node_st_t             rst_st;
  logic [SIZE_BITS-1:0] rsize;
  logic                 rd_issue;

  assign rst_st = node_st_t'(rdata[NODE_W-1 -: 2]);
  assign rsize  = rdata[SIZE_BITS-1:0];

  bba_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_store (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  // Memory port control
  always_comb begin
    we    = 1'b0;
    addr  = ptr_r;
    wdata = {ST_FREE, {SIZE_BITS{1'b0}}};
    if (cmd.clear_step) begin
      we = 1'b1;
    end else if (cmd.take) begin
      we = 1'b1; addr = cand_r; wdata = {ST_ALLOC, req_r};
    end else if (cmd.mark_step) begin
      we = (rst_st == ST_FREE); wdata = {ST_DIVIDED, {SIZE_BITS{1'b0}}};
    end else if (cmd.free_take) begin
      we = 1'b1;
    end else if (cmd.merge_step) begin
      we = 1'b1; addr = ptr_r >> 1;
    end
  end

  // Every scan, walk or merge pointer move starts a read (clearing does not); rd_valid follows via rdq_r and rdv_r
  assign rd_issue = cmd.scan_init | cmd.scan_rd | cmd.anc_step | cmd.scan_next
                  | cmd.take | cmd.mark_step | cmd.fscan_init | cmd.fscan_next
                  | cmd.free_take | cmd.merge_step;

  // level_of for found node
  function automatic logic [LVL_BITS-1:0] lvl_of(logic [NODE_BITS-1:0] n);
    logic [LVL_BITS-1:0] l;
    l = '0;
    for (int b = 1; b < NODE_BITS; b++) begin
      if (n[b]) l = LVL_BITS'(b);
    end
    return l;
  endfunction

  logic [NODE_BITS-1:0] lvl_first;
  logic [NODE_BITS-1:0] lvl_last;
  assign lvl_first = NODE_BITS'(1) << lvl_r;
  assign lvl_last  = NODE_BITS'((NODE_BITS'(1) << lvl_r) - 1) | lvl_first;

  always_comb begin
    sts            = '0;
    sts.clear_done = (ptr_r == NODE_BITS'(NODE_COUNT - 1));
    sts.zero_req   = (in_request_size == '0);
    sts.is_free    = in_kind;
    sts.exceeds    = (req_r > total_r);
    sts.level_done = ((req_r <= sz_r) && (req_r > (sz_r >> 1)))
                     || (lvl_r == LVL_BITS'(TREE_LEVELS - 1));
    sts.rd_valid   = rdv_r;
    sts.cand_free  = (rst_st == ST_FREE);
    sts.anc_done   = (ptr_r <= NODE_BITS'(1)) || (rst_st != ST_FREE);
    sts.anc_ok     = (ptr_r <= NODE_BITS'(1) && rst_st == ST_FREE)
                     || (rst_st == ST_DIVIDED);
    sts.scan_last  = (cand_r == lvl_last);
    sts.mark_done  = (ptr_r <= NODE_BITS'(1)) || (rst_st != ST_FREE);
    sts.fmatch     = (rst_st == ST_ALLOC) && (rsize == req_r);
    sts.fscan_last = ({1'b0, ptr_r} + 1'b1 >= fend_r);
    sts.merge_done = (ptr_r <= NODE_BITS'(1)) || (rst_st != ST_FREE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
      deep_r  <= '0;
      rdq_r   <= 1'b0;
      rdv_r   <= 1'b0;
      ptr_r   <= '0;
    end else begin
      if (cfg_wr_en) total_r <= cfg_wr_data;
      rdq_r <= rd_issue;
      rdv_r <= rdq_r;
      if (cmd.clear_init) ptr_r <= '0;
      if (cmd.clear_step) ptr_r <= ptr_r + 1'b1;
      if (cmd.load) begin
        req_r  <= in_request_size;
        sz_r   <= total_r;
        lvl_r  <= '0;
      end
      if (cmd.level_step) begin
        sz_r  <= sz_r >> 1;
        lvl_r <= lvl_r + 1'b1;
      end
      if (cmd.scan_init) begin
        cand_r <= lvl_first; ptr_r <= lvl_first;
      end
      if (cmd.scan_rd || cmd.anc_step) begin
        ptr_r <= ptr_r >> 1;
      end
      if (cmd.scan_next) begin
        cand_r <= cand_r + 1'b1; ptr_r <= cand_r + 1'b1;
      end
      if (cmd.take) begin
        ptr_r <= cand_r >> 1;
        if (lvl_r > deep_r) deep_r <= lvl_r;
      end
      if (cmd.mark_step) begin
        ptr_r <= ptr_r >> 1;
      end
      if (cmd.fscan_init) begin
        ptr_r  <= NODE_BITS'(1);
        fend_r <= ((NODE_BITS+1)'(1) << (deep_r + 1'b1));
      end
      if (cmd.fscan_next) begin
        ptr_r <= ptr_r + 1'b1;
      end
      if (cmd.free_take) begin
        cand_r <= ptr_r; ptr_r <= ptr_r ^ NODE_BITS'(1);
      end
      if (cmd.merge_step) begin
        ptr_r <= (ptr_r >> 1) ^ NODE_BITS'(1);
      end
      if (cmd.set_res) begin
        st_r <= cmd.res;
        nd_r <= (cmd.res == RES_OK) ? cand_r : '0;
        lv_r <= (cmd.res == RES_OK) ? lvl_of(cand_r) : '0;
      end
    end
  end

  assign res_status = st_r;
  assign res_node   = nd_r;
  assign res_level  = lv_r;
endmodule

>>> src/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer for allocate and free operations.
// ----------------------------------------------------------------------------
module bba_ctrl
  import bba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);
  fsm_t state_r, state_nxt;
  logic ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign in_stall  = (state_r != S_IDLE) || ov_r;

  always_comb begin
    cmd       = '0;
    cmd.res   = RES_OK;
    state_nxt = state_r;
    ov_nxt    = ov_r && out_stall;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && !ov_r) begin
          cmd.load = 1'b1;
          if (sts.zero_req) begin
            cmd.set_res = 1'b1; cmd.res = RES_ZERO; state_nxt = S_DONE;
          end else if (sts.is_free) begin
            cmd.fscan_init = 1'b1; state_nxt = S_FSCAN;
          end else begin
            state_nxt = S_LEVEL;
          end
        end
      end
      S_LEVEL: begin
        if (sts.exceeds) begin
          cmd.set_res = 1'b1; cmd.res = RES_EXCEEDS; state_nxt = S_DONE;
        end else if (sts.level_done) begin
          cmd.scan_init = 1'b1; state_nxt = S_SCAN;
        end else begin
          cmd.level_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (sts.rd_valid) begin
          if (sts.cand_free) begin
            cmd.scan_rd = 1'b1; state_nxt = S_ANC;
          end else if (sts.scan_last) begin
            cmd.set_res = 1'b1; cmd.res = RES_NO_FREE; state_nxt = S_DONE;
          end else begin
            cmd.scan_next = 1'b1;
          end
        end
      end
      S_ANC: begin
        // pointer already moved to parent; data is of the node read last
        if (sts.rd_valid) begin
          if (sts.anc_done) begin
            if (sts.anc_ok) begin
              cmd.take = 1'b1; state_nxt = S_MARK;
            end else if (sts.scan_last) begin
              cmd.set_res = 1'b1; cmd.res = RES_NO_FREE; state_nxt = S_DONE;
            end else begin
              cmd.scan_next = 1'b1; state_nxt = S_SCAN;
            end
          end else begin
            cmd.anc_step = 1'b1;
          end
        end
      end
      S_MARK: begin
        if (sts.rd_valid) begin
          cmd.mark_step = 1'b1;
          if (sts.mark_done) begin
            cmd.set_res = 1'b1; state_nxt = S_DONE;
          end
        end
      end
      S_FSCAN: begin
        if (sts.rd_valid) begin
          if (sts.fmatch) begin
            cmd.free_take = 1'b1; state_nxt = S_MERGE;
          end else if (sts.fscan_last) begin
            cmd.set_res = 1'b1; cmd.res = RES_NOT_FOUND; state_nxt = S_DONE;
          end else begin
            cmd.fscan_next = 1'b1;
          end
        end
      end
      S_MERGE: begin
        if (sts.rd_valid) begin
          if (sts.merge_done) begin
            cmd.set_res = 1'b1; state_nxt = S_DONE;
          end else begin
            cmd.merge_step = 1'b1;
          end
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> src/buddy_block_allocator.sv
// A zero request, or an allocate above total_size, is answered without reading the
//   node store; an allocate runs a level search, a scan of a level with an ancestor
//   walk per free candidate, and parent marking; a free scans and then merges buddies.
// Throughput: one request at a time; each node store read is registered.
// Reset: synchronous active low; then all 32 nodes are cleared, no requests taken.
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a five-level binary tree of block nodes.
// ----------------------------------------------------------------------------
module buddy_block_allocator
  import bba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [SIZE_BITS-1:0] cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_kind,
  input  logic [SIZE_BITS-1:0] in_request_size,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_status,
  output logic [NODE_BITS-1:0] out_node_index,
  output logic [LVL_BITS-1:0]  out_block_level
);
  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns handshakes and the walk order
  bba_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts(sts), .cmd(cmd)
  );

  // Datapath: node store, scan pointers, result register
  bba_datapath u_dp (
    .clk, .rst_n, .cmd(cmd), .sts(sts), .cfg_wr_en, .cfg_wr_data,
    .in_kind, .in_request_size,
    .res_status(out_status), .res_node(out_node_index), .res_level(out_block_level)
  );
endmodule

>>> src/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the allocator.
// ----------------------------------------------------------------------------
module bba_checker
  import bba_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [2:0]           out_status,
  input logic [NODE_BITS-1:0] out_node_index,
  input logic [LVL_BITS-1:0]  out_block_level
);
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != RES_OK |-> out_node_index == '0 && out_block_level == '0)
    else $error("failed result carries a node");
  a_ok_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == RES_OK |-> out_node_index != '0)
    else $error("ok result with node zero");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result changed");
endmodule

bind buddy_block_allocator bba_checker u_chk (.*);

>>> tb/buddy_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_tb
// Self-checking bench for the buddy allocator. Allocate and free requests
// are checked against an in-bench tree model: directed corner cases first,
// then random phases at several memory sizes. Both sides idle in bursts.
// ----------------------------------------------------------------------------
module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int KIND_ALLOC = 0;
  localparam int KIND_FREE  = 1;
  localparam int SETTLE_CYC = 200;  // longer than the worst request latency

  typedef struct {
    res_t                 status;
    logic [NODE_BITS-1:0] node;
    logic [LVL_BITS-1:0]  lvl;
  } alloc_res_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [SIZE_BITS-1:0] cfg_wr_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_kind;
  logic [SIZE_BITS-1:0] in_request_size;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           out_status;
  logic [NODE_BITS-1:0] out_node_index;
  logic [LVL_BITS-1:0]  out_block_level;

  buddy_block_allocator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_request_size (in_request_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_node_index  (out_node_index),
    .out_block_level (out_block_level)
  );

  // Tree model: node 1 is the root, children of n are 2n and 2n+1
  node_st_t             tree_st [NODE_COUNT];
  logic [SIZE_BITS-1:0] tree_sz [NODE_COUNT];
  int                   deepest_lvl;
  logic [SIZE_BITS-1:0] mem_size;

  alloc_res_t pending_res[$];
  int  n_errors;
  int  n_sent;
  int  n_checked;
  int  n_ok;
  int  n_fail_status;
  bit  quiet;        // no idling on either side
  int  gap_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[buddy_block_allocator] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic bit path_open(int nd);
    // walk up; first non-free ancestor decides
    while (nd > 1) begin
      nd = nd >> 1;
      if (tree_st[nd] != ST_FREE) return tree_st[nd] == ST_DIVIDED;
    end
    return 1'b1;
  endfunction

  function automatic alloc_res_t predict_alloc(logic [SIZE_BITS-1:0] req);
    alloc_res_t r;
    int lv;
    int s;
    r.status = RES_NO_FREE;
    r.node   = '0;
    r.lvl    = '0;
    lv = 0;
    s  = mem_size;
    if (req > mem_size) begin
      r.status = RES_EXCEEDS;
      return r;
    end
    // fitting level, clamped to the leaf level
    while (!(req <= s && req > s / 2) && lv < TREE_LEVELS - 1) begin
      s  = s / 2;
      lv = lv + 1;
    end
    for (int i = 1 << lv; i < (1 << (lv + 1)); i++) begin
      if (tree_st[i] == ST_FREE && path_open(i)) begin
        tree_st[i] = ST_ALLOC;
        tree_sz[i] = req;
        for (int p = i >> 1; p >= 1 && tree_st[p] == ST_FREE; p = p >> 1)
          tree_st[p] = ST_DIVIDED;
        if (lv > deepest_lvl) deepest_lvl = lv;
        r.status = RES_OK;
        r.node   = NODE_BITS'(i);
        r.lvl    = LVL_BITS'(lv);
        return r;
      end
    end
    return r;
  endfunction

  function automatic alloc_res_t predict_free(logic [SIZE_BITS-1:0] req);
    alloc_res_t r;
    int hit;
    int lim;
    int nd;
    int lv;
    r.status = RES_NOT_FOUND;
    r.node   = '0;
    r.lvl    = '0;
    hit = 0;
    lim = 1 << (deepest_lvl + 1);
    if (lim > NODE_COUNT) lim = NODE_COUNT;
    for (int i = 1; i < lim; i++) begin
      if (tree_st[i] == ST_ALLOC && tree_sz[i] == req) begin
        hit = i;
        break;
      end
    end
    if (hit == 0) return r;
    tree_st[hit] = ST_FREE;
    tree_sz[hit] = '0;
    nd = hit;
    // merge while the buddy is free
    while (nd > 1) begin
      if (tree_st[nd ^ 1] != ST_FREE) break;
      nd = nd >> 1;
      tree_st[nd] = ST_FREE;
      tree_sz[nd] = '0;
    end
    lv = 0;
    nd = hit;
    while (nd > 1) begin
      nd = nd >> 1;
      lv++;
    end
    r.status = RES_OK;
    r.node   = NODE_BITS'(hit);
    r.lvl    = LVL_BITS'(lv);
    return r;
  endfunction

  function automatic alloc_res_t predict_request(bit kind, logic [SIZE_BITS-1:0] req);
    alloc_res_t r;
    if (req == '0) begin
      r.status = RES_ZERO;
      r.node   = '0;
      r.lvl    = '0;
    end else if (kind == KIND_ALLOC) begin
      r = predict_alloc(req);
    end else begin
      r = predict_free(req);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  task automatic send_request(bit kind, logic [SIZE_BITS-1:0] req);
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_request_size <= req;
    do @(posedge clk); while (in_stall);
    pending_res.push_back(predict_request(kind, req));
    n_sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain_requests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_mem_size(logic [SIZE_BITS-1:0] val);
    drain_requests();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mem_size     = val;
  endtask

  // receiver idles in bursts
  initial begin
    out_stall = 1'b0;
    gap_left  = 0;
    forever begin
      @(posedge clk);
      if (gap_left > 0) begin
        gap_left--;
        if (gap_left == 0) out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        gap_left  = $urandom_range(1, 11);
        out_stall <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("mismatch %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    alloc_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, -1);
      end else begin
        want = pending_res.pop_front();
        n_checked++;
        if (want.status == RES_OK) n_ok++;
        else n_fail_status++;
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_node_index !== want.node)
          report_mismatch("node_index", out_node_index, want.node);
        if (out_block_level !== want.lvl)
          report_mismatch("block_level", out_block_level, want.lvl);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // size that mostly fits a random level of the current memory; else zero, random or above memory
  function automatic logic [SIZE_BITS-1:0] pick_size();
    int s;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return SIZE_BITS'($urandom_range(0, 65535));
    if (pick == 2) return (mem_size == 16'hFFFF) ? 16'hFFFF : SIZE_BITS'(mem_size + 1);
    s = mem_size >> $urandom_range(0, TREE_LEVELS - 1);
    if (s <= 1) return SIZE_BITS'(1);
    return SIZE_BITS'($urandom_range(s / 2 + 1, s));
  endfunction

  // free size: mostly one held by an allocated node
  function automatic logic [SIZE_BITS-1:0] pick_free_size();
    int held[$];
    for (int i = 1; i < NODE_COUNT; i++)
      if (tree_st[i] == ST_ALLOC) held.push_back(i);
    if (held.size() != 0 && $urandom_range(0, 9) < 8)
      return tree_sz[held[$urandom_range(0, held.size() - 1)]];
    return pick_size();
  endfunction

  task automatic test_corner_cases();
    send_request(KIND_ALLOC, 16'd0);       // zero allocate
    send_request(KIND_FREE, 16'd0);        // zero free
    send_request(KIND_ALLOC, 16'd1025);    // above memory
    send_request(KIND_ALLOC, 16'hFFFF);
    send_request(KIND_ALLOC, 16'd1024);    // whole root
    send_request(KIND_ALLOC, 16'd1);       // root taken: no free block
    send_request(KIND_FREE, 16'd1024);
    send_request(KIND_FREE, 16'd1024);     // already freed: not found
    for (int i = 0; i < 16; i++)
      send_request(KIND_ALLOC, 16'd1);     // clamped to leaf level
    send_request(KIND_ALLOC, 16'd1);       // leaves exhausted
    send_request(KIND_FREE, 16'd1);
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 1) == 0) send_request(KIND_ALLOC, pick_size());
      else send_request(KIND_FREE, pick_free_size());
    end
  endtask

  task automatic test_full_drain_pause(int count);
    // sender stops until every result is back, mid-traffic
    test_random_mix(count / 2);
    drain_requests();
    test_random_mix(count - count / 2);
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_kind         = 1'b0;
    in_request_size = '0;
    quiet           = 1'b0;
    n_errors        = 0;
    n_sent          = 0;
    n_checked       = 0;
    n_ok            = 0;
    n_fail_status   = 0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      tree_st[i] = ST_FREE;
      tree_sz[i] = '0;
    end
    deepest_lvl = 0;
    mem_size    = TOTAL_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_corner_cases();
    test_full_drain_pause(380);
    write_mem_size(16'hFFFF);
    test_random_mix(400);
    write_mem_size(16'd1);
    test_random_mix(150);
    write_mem_size(SIZE_BITS'($urandom_range(2, 65534)));
    test_random_mix(150);
    write_mem_size(16'd1024);
    quiet = 1'b1;                          // last stretch runs back to back
    test_random_mix(200);
    drain_requests();

    $display("covered %0d requests, %0d checked: %0d granted, %0d refused",
             n_sent, n_checked, n_ok, n_fail_status);
    $display("memory sizes 1024, 65535, 1 and random; idle bursts both sides");
    if (n_errors == 0 && pending_res.size() == 0) begin
      $display("[buddy_block_allocator] OK");
    end else begin
      $display("[buddy_block_allocator] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/bba_pkg.sv
src/bba_ram.sv
src/bba_datapath.sv
src/bba_ctrl.sv
src/buddy_block_allocator.sv
src/bba_checker.sv
tb/buddy_block_allocator_tb.sv
